/* hw/rtl/dtnf_pkg.sv */
// dtnf_pkg: shared types and constants of the duty to nits eased fader
// used by dtnf_div, dtnf_ctrl, dtnf_dp and the top level
package dtnf_pkg;

	localparam int unsigned DUTY_W = 32;
	localparam int unsigned LVL_W  = 16;
	localparam int unsigned STEP_W = 8;
	localparam int unsigned CFG_W  = 32;
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned DVD_W  = 48;
	localparam int unsigned DVS_W  = 32;
	localparam int unsigned PROD_W = 40;
	localparam int unsigned CUBE_W = 24;

	localparam logic [LVL_W-1:0]  FULL_LEVEL    = 16'hFFFF;
	localparam logic [DUTY_W-1:0] PERIOD_RESET  = 32'd120000;
	localparam logic [LVL_W-1:0]  NITS_RESET    = 16'd440;
	localparam logic [STEP_W-1:0] STEPS_RESET   = 8'd12;

	localparam logic [IDX_W-1:0] REG_PERIOD = 2'd0;
	localparam logic [IDX_W-1:0] REG_NITS   = 2'd1;
	localparam logic [IDX_W-1:0] REG_STEPS  = 2'd2;
	localparam logic [IDX_W-1:0] REG_ENABLE = 2'd3;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_TGT_FULL,
		OP_TDIV_GO,
		OP_TGT_Q,
		OP_DECIDE,
		OP_STEP,
		OP_MUL_NN,
		OP_MUL_D3,
		OP_MUL_XX,
		OP_MUL_X3,
		OP_FRAC,
		OP_MUL_DF,
		OP_EDIV_GO,
		OP_EASE,
		OP_MUL_NITS,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_TDIV,
		S_DECIDE,
		S_STEP,
		S_NN,
		S_D3,
		S_XX,
		S_X3,
		S_FRAC,
		S_MDF,
		S_EDIV_GO,
		S_EDIV,
		S_MNITS,
		S_OUT
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic go;
		logic duty_ge;
		logic fading;
		logic finish;
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

/* hw/rtl/duty_to_nits_eased_fader_top.sv */
// duty_to_nits_eased_fader_top: PWM duty to eased panel brightness and nits
// depends on dtnf_pkg, dtnf_ctrl, dtnf_dp
//
// usage
// - input channel in_valid/in_ready carries one duty word per poll tick
// - output channel out_valid/out_ready carries level, nits and fade_done
// - config port cfg_we/cfg_index/cfg_data writes period, max nits, fade
//   length and enable, one register per cycle, no read-back
// - a disabled tick frees the input again from the check state, a tick
//   with no result from the step state
// - in a fade step the target and easing divisions go one quotient bit
//   per cycle through the single 48-bit divider, the cube terms share
//   one 24x16 multiplier and nits divide by 65535 with a shift and add
// - a fade's last step skips the cube terms and the easing division;
//   a duty at or above the period skips the target division
// - one word is worked on at a time; in_ready is high only between ticks,
//   the next word can be taken in the cycle after the result is written
// - the result sits in an output register, so the next tick is taken while
//   a result waits; a stalled receiver holds the sequencer before its next
//   result is written
// - reset clears config to its defaults, level to full and stops any fade
module duty_to_nits_eased_fader_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dtnf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [dtnf_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [dtnf_pkg::DUTY_W-1:0] duty,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dtnf_pkg::LVL_W-1:0]  level,
	output logic [dtnf_pkg::LVL_W-1:0]  nits,
	output logic                        fade_done
);
	import dtnf_pkg::*;

	cmd_t    cmd;
	status_t stat;

	dtnf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dtnf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.duty      (duty),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.level     (level),
		.nits      (nits),
		.fade_done (fade_done)
	);
endmodule

/* hw/rtl/dtnf_div.sv */
// dtnf_div: restoring divider, one quotient bit per cycle
// depends on dtnf_pkg
module dtnf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dtnf_pkg::DVD_W-1:0]  dividend,
	input  logic [dtnf_pkg::DVS_W-1:0]  divisor,
	output logic                        busy,
	output logic [dtnf_pkg::DVD_W-1:0]  quotient
);
	import dtnf_pkg::*;

	localparam int unsigned CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   trial;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DVS_W]) begin
				rem_q <= trial[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

/* hw/rtl/dtnf_ctrl.sv */
// dtnf_ctrl: sequencer that steps the datapath through one tick
// depends on dtnf_pkg
module dtnf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dtnf_pkg::status_t stat,
	output dtnf_pkg::cmd_t    cmd
);
	import dtnf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!stat.go) begin
					state_d = S_IDLE;
				end else if (stat.duty_ge) begin
					cmd.op  = OP_TGT_FULL;
					state_d = S_DECIDE;
				end else begin
					cmd.op  = OP_TDIV_GO;
					state_d = S_TDIV;
				end
			end
			S_TDIV: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_TGT_Q;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.op  = OP_DECIDE;
				state_d = S_STEP;
			end
			S_STEP: begin
				if (!stat.fading) begin
					state_d = S_IDLE;
				end else begin
					cmd.op  = OP_STEP;
					state_d = stat.finish ? S_MNITS : S_NN;
				end
			end
			S_NN: begin
				cmd.op  = OP_MUL_NN;
				state_d = S_D3;
			end
			S_D3: begin
				cmd.op  = OP_MUL_D3;
				state_d = S_XX;
			end
			S_XX: begin
				cmd.op  = OP_MUL_XX;
				state_d = S_X3;
			end
			S_X3: begin
				cmd.op  = OP_MUL_X3;
				state_d = S_FRAC;
			end
			S_FRAC: begin
				cmd.op  = OP_FRAC;
				state_d = S_MDF;
			end
			S_MDF: begin
				cmd.op  = OP_MUL_DF;
				state_d = S_EDIV_GO;
			end
			S_EDIV_GO: begin
				cmd.op  = OP_EDIV_GO;
				state_d = S_EDIV;
			end
			S_EDIV: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_EASE;
					state_d = S_MNITS;
				end
			end
			S_MNITS: begin
				cmd.op  = OP_MUL_NITS;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

/* hw/rtl/dtnf_dp.sv */
// dtnf_dp: configuration, fade state, shared multiplier, divider and output register
// depends on dtnf_pkg and dtnf_div
module dtnf_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dtnf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [dtnf_pkg::CFG_W-1:0]  cfg_data,
	input  logic [dtnf_pkg::DUTY_W-1:0] duty,
	input  dtnf_pkg::cmd_t              cmd,
	output dtnf_pkg::status_t           stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dtnf_pkg::LVL_W-1:0]  level,
	output logic [dtnf_pkg::LVL_W-1:0]  nits,
	output logic                        fade_done
);
	import dtnf_pkg::*;

	logic [DUTY_W-1:0] period_q;
	logic [LVL_W-1:0]  max_nits_q;
	logic [STEP_W-1:0] steps_q;
	logic              enable_q;

	logic [DUTY_W-1:0] duty_q;
	logic [DUTY_W-1:0] last_duty_q;
	logic [LVL_W-1:0]  origin_q;
	logic [LVL_W-1:0]  goal_q;
	logic [LVL_W-1:0]  target_q;
	logic [STEP_W-1:0] step_q;
	logic              fading_q;
	logic [LVL_W-1:0]  cur_level_q;
	logic              done_q;

	logic [PROD_W-1:0] prod_q;
	logic [CUBE_W-1:0] d3_q;
	logic [CUBE_W-1:0] frac_q;

	logic              out_valid_q;
	logic [LVL_W-1:0]  level_q;
	logic [LVL_W-1:0]  nits_q;
	logic              fade_done_q;

	logic [STEP_W-1:0] step_inc;
	logic              half;
	logic [STEP_W-1:0] rem_steps;
	logic [STEP_W-1:0] x_val;
	logic              neg;
	logic [LVL_W-1:0]  abs_diff;
	logic [CUBE_W-1:0] mul_a;
	logic [LVL_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_p;
	logic [32:0]       nits_sum;

	logic              div_start;
	logic [DVD_W-1:0]  div_dvd;
	logic [DVS_W-1:0]  div_dvs;
	logic              div_busy;
	logic [DVD_W-1:0]  div_quo;

	assign step_inc  = step_q + 1'b1;
	assign half      = {step_q, 1'b0} < {1'b0, steps_q};
	assign rem_steps = steps_q - step_q;
	assign x_val     = half ? step_q : {rem_steps[STEP_W-2:0], 1'b0};
	assign neg       = goal_q < origin_q;
	assign abs_diff  = neg ? (origin_q - goal_q) : (goal_q - origin_q);
	assign mul_p     = mul_a * mul_b;

	// divide by 65535 as (p + (p >> 16) + 1) >> 16
	assign nits_sum = {1'b0, prod_q[31:0]} + {17'd0, prod_q[31:16]} + 33'd1;

	assign stat.go       = enable_q && (period_q != '0);
	assign stat.duty_ge  = duty_q >= period_q;
	assign stat.fading   = fading_q;
	assign stat.finish   = (step_inc >= steps_q) || (step_inc == '0);
	assign stat.div_busy = div_busy;
	assign stat.out_free = !out_valid_q || out_ready;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_NN: begin
				mul_a = CUBE_W'(steps_q);
				mul_b = LVL_W'(steps_q);
			end
			OP_MUL_D3: begin
				mul_a = CUBE_W'(prod_q[LVL_W-1:0]);
				mul_b = LVL_W'(steps_q);
			end
			OP_MUL_XX: begin
				mul_a = CUBE_W'(x_val);
				mul_b = LVL_W'(x_val);
			end
			OP_MUL_X3: begin
				mul_a = CUBE_W'(prod_q[LVL_W-1:0]);
				mul_b = LVL_W'(x_val);
			end
			OP_MUL_DF: begin
				mul_a = frac_q;
				mul_b = abs_diff;
			end
			OP_MUL_NITS: begin
				mul_a = CUBE_W'(cur_level_q);
				mul_b = max_nits_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		case (cmd.op)
			OP_TDIV_GO: begin
				div_start = 1'b1;
				div_dvd   = {duty_q, 16'h0000} - DVD_W'(duty_q);
				div_dvs   = period_q;
			end
			OP_EDIV_GO: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(prod_q);
				div_dvs   = DVS_W'(d3_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	dtnf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// config and fade state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			max_nits_q  <= NITS_RESET;
			steps_q     <= STEPS_RESET;
			enable_q    <= 1'b0;
			last_duty_q <= '0;
			origin_q    <= '0;
			goal_q      <= '0;
			step_q      <= '0;
			fading_q    <= 1'b0;
			cur_level_q <= FULL_LEVEL;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PERIOD: period_q   <= cfg_data;
					REG_NITS:   max_nits_q <= cfg_data[LVL_W-1:0];
					REG_STEPS:  steps_q    <= cfg_data[STEP_W-1:0];
					REG_ENABLE: enable_q   <= cfg_data[0];
					default:    enable_q   <= enable_q;
				endcase
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_DECIDE: begin
					if (duty_q != last_duty_q) begin
						last_duty_q <= duty_q;
						origin_q    <= cur_level_q;
						goal_q      <= target_q;
						step_q      <= '0;
						fading_q    <= 1'b1;
					end
				end
				OP_STEP: begin
					step_q <= step_inc;
					done_q <= stat.finish;
					if (stat.finish) begin
						cur_level_q <= goal_q;
						fading_q    <= 1'b0;
					end
				end
				OP_EASE: begin
					cur_level_q <= neg ? (origin_q - div_quo[LVL_W-1:0])
						: (origin_q + div_quo[LVL_W-1:0]);
				end
				default: begin
					done_q <= done_q;
				end
			endcase
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH:    duty_q   <= duty;
			OP_TGT_FULL: target_q <= FULL_LEVEL;
			OP_TGT_Q:    target_q <= div_quo[LVL_W-1:0];
			OP_MUL_XX: begin
				d3_q   <= prod_q[CUBE_W-1:0];
				prod_q <= mul_p;
			end
			OP_MUL_NN, OP_MUL_D3, OP_MUL_X3, OP_MUL_DF, OP_MUL_NITS: begin
				prod_q <= mul_p;
			end
			OP_FRAC: begin
				frac_q <= half ? {prod_q[CUBE_W-3:0], 2'b00} : (d3_q - prod_q[CUBE_W:1]);
			end
			OP_OUT: begin
				level_q     <= cur_level_q;
				nits_q      <= nits_sum[31:16];
				fade_done_q <= done_q;
			end
			default: begin
				duty_q <= duty_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign nits      = nits_q;
	assign fade_done = fade_done_q;
endmodule
